/* design/adrc_pkg.sv */
// ----------------------------------------------------------------------------
// adrc_pkg: shared constants and types of the dynamic range compressor
// Register codes, reset values, conversion constants and the request
// control word passed from the front end to the gain back end.
// ----------------------------------------------------------------------------
package adrc_pkg;

  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int DB_FRAC_BITS_DEF = 8;
  localparam int TIMER_BITS_DEF   = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int THR_W      = 16;
  localparam int RATIO_W    = 15;
  localparam int TICKS_W    = 16;
  localparam int OVER_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_DB  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_TICKS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS = 2'd3;

  localparam logic signed [THR_W-1:0] THRESHOLD_RST = 16'sd1280;
  localparam logic [RATIO_W-1:0]      RATIO_RST     = 15'd16384;
  localparam logic [TICKS_W-1:0]      ATTACK_RST    = 16'd22050;
  localparam logic [TICKS_W-1:0]      RELEASE_RST   = 16'd22050;

  localparam int MANT_BITS  = 24;
  localparam int FRAC_STEPS = 12;

  // 20*log10(2) and log2(10)/20, both Q16
  localparam logic [18:0] LOG_C = 19'd394566;
  localparam logic [13:0] EXP_K = 14'd10885;

  localparam logic [MANT_BITS-1:0] MANT_ONE = 24'd8388608;

  // 2^(2^-(i+1)) for entry i, in Q1.23
  localparam logic [MANT_BITS-1:0] POW2_TAB [FRAC_STEPS] = '{
    24'd11863283, 24'd9975792, 24'd9147842, 24'd8760003,
    24'd8572295,  24'd8479954, 24'd8434157, 24'd8411352,
    24'd8399972,  24'd8394288, 24'd8391448, 24'd8390028
  };

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  typedef struct packed {
    logic gain;
    logic sub;
    logic gate;
  } ctrl_t;

  localparam int CTRL_W = $bits(ctrl_t);

  function automatic int db_width(input int dbf);
    return (dbf + 9 > 17) ? dbf + 9 : 17;
  endfunction

endpackage

/* design/audio_dynamic_range_compressor.sv */
// ----------------------------------------------------------------------------
// audio_dynamic_range_compressor: hard-knee compressor with gate timers
// Samples go in through a queue-style push/full port and results come out
// through an empty/pop port; sample_out and gate_open show the oldest
// waiting result while empty is low. Stereo channels are consecutive
// samples sharing one gate state.
// Throughput is one sample per cycle unless a stalled pop holds it: the log
// detector (12 squaring stages) and the exponent (12 table multiply stages)
// are fully pipelined.
// A four-entry queue separates level detection and gate control from the
// gain back end; a two-entry output queue holds finished results. When pop
// stays low the back end halts, the middle queue fills, and then full
// rises; no request is dropped.
// cfg_ready is always high; the user must write registers only while idle;
// the block does not enforce it. Synchronous reset loads register defaults,
// closes the gate, clears the timer and overshoot and empties both queues.
// ----------------------------------------------------------------------------
module audio_dynamic_range_compressor #(
  parameter int SAMPLE_BITS  = adrc_pkg::SAMPLE_BITS_DEF,
  parameter int DB_FRAC_BITS = adrc_pkg::DB_FRAC_BITS_DEF,
  parameter int TIMER_BITS   = adrc_pkg::TIMER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic signed [SAMPLE_BITS-1:0]      sample_in,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [SAMPLE_BITS-1:0]      sample_out,
  output logic                               gate_open,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [adrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adrc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DB_W  = adrc_pkg::db_width(DB_FRAC_BITS);
  localparam int OV_W  = adrc_pkg::OVER_W;
  localparam int MID_W = adrc_pkg::CTRL_W + SAMPLE_BITS + OV_W + DB_W;
  localparam int OUT_W = SAMPLE_BITS + 1;

  logic signed [adrc_pkg::THR_W-1:0] threshold_db;
  logic [adrc_pkg::RATIO_W-1:0]      ratio;
  logic [adrc_pkg::TICKS_W-1:0]      attack_ticks;
  logic [adrc_pkg::TICKS_W-1:0]      release_ticks;

  logic                   f_wr, mid_full, mid_empty, b_pop;
  adrc_pkg::ctrl_t        f_ctrl, b_ctrl;
  logic [SAMPLE_BITS-1:0] f_sample, b_sample;
  logic signed [OV_W-1:0] f_op, b_op;
  logic signed [DB_W-1:0] f_base, b_base;
  logic [MID_W-1:0]       mid_rd;

  logic                   o_wr, o_full, o_gate;
  logic [SAMPLE_BITS-1:0] o_sample;
  logic [OUT_W-1:0]       out_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_db  <= adrc_pkg::THRESHOLD_RST;
      ratio         <= adrc_pkg::RATIO_RST;
      attack_ticks  <= adrc_pkg::ATTACK_RST;
      release_ticks <= adrc_pkg::RELEASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        adrc_pkg::REG_THRESHOLD_DB:  threshold_db  <= cfg_data;
        adrc_pkg::REG_RATIO:         ratio         <= cfg_data[adrc_pkg::RATIO_W-1:0];
        adrc_pkg::REG_ATTACK_TICKS:  attack_ticks  <= cfg_data;
        adrc_pkg::REG_RELEASE_TICKS: release_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  adrc_front #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .DB_FRAC_BITS (DB_FRAC_BITS),
    .TIMER_BITS   (TIMER_BITS),
    .DB_W         (DB_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .sample_in     (sample_in),
    .threshold_db  (threshold_db),
    .attack_ticks  (attack_ticks),
    .release_ticks (release_ticks),
    .q_full        (mid_full),
    .q_wr          (f_wr),
    .q_ctrl        (f_ctrl),
    .q_sample      (f_sample),
    .q_op          (f_op),
    .q_base        (f_base)
  );

  adrc_fifo #(
    .WIDTH (MID_W),
    .DEPTH (adrc_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_wr),
    .wr_data ({f_ctrl, f_sample, f_op, f_base}),
    .full    (mid_full),
    .rd_en   (b_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  assign {b_ctrl, b_sample, b_op, b_base} = mid_rd;

  adrc_back #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .DB_FRAC_BITS (DB_FRAC_BITS),
    .DB_W         (DB_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (mid_empty),
    .q_pop    (b_pop),
    .q_ctrl   (b_ctrl),
    .q_sample (b_sample),
    .q_op     (b_op),
    .q_base   (b_base),
    .ratio    (ratio),
    .o_full   (o_full),
    .o_wr     (o_wr),
    .o_sample (o_sample),
    .o_gate   (o_gate)
  );

  adrc_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (adrc_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (o_wr),
    .wr_data ({o_gate, o_sample}),
    .full    (o_full),
    .rd_en   (pop),
    .rd_data (out_rd),
    .empty   (empty)
  );

  assign sample_out = out_rd[SAMPLE_BITS-1:0];
  assign gate_open  = out_rd[SAMPLE_BITS];

endmodule

/* design/adrc_fifo.sv */
// ----------------------------------------------------------------------------
// adrc_fifo: small synchronous queue
// Register-based queue with push/pop guarding; head entry shown directly.
// ----------------------------------------------------------------------------
module adrc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             wr;
  logic             rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign wr      = wr_en && !full;
  assign rd      = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

/* design/adrc_front.sv */
// ----------------------------------------------------------------------------
// adrc_front: level detector and gate state
// Pipelined magnitude-to-dB conversion (leading one, 12 squaring stages,
// scale), then threshold compare, gate, timer and overshoot update.
// ----------------------------------------------------------------------------
module adrc_front #(
  parameter int SAMPLE_BITS  = adrc_pkg::SAMPLE_BITS_DEF,
  parameter int DB_FRAC_BITS = adrc_pkg::DB_FRAC_BITS_DEF,
  parameter int TIMER_BITS   = adrc_pkg::TIMER_BITS_DEF,
  parameter int DB_W         = adrc_pkg::db_width(DB_FRAC_BITS)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in,
  input  logic signed [adrc_pkg::THR_W-1:0]    threshold_db,
  input  logic [adrc_pkg::TICKS_W-1:0]         attack_ticks,
  input  logic [adrc_pkg::TICKS_W-1:0]         release_ticks,
  input  logic                                 q_full,
  output logic                                 q_wr,
  output adrc_pkg::ctrl_t                      q_ctrl,
  output logic [SAMPLE_BITS-1:0]               q_sample,
  output logic signed [adrc_pkg::OVER_W-1:0]   q_op,
  output logic signed [DB_W-1:0]               q_base
);

  localparam int SB     = SAMPLE_BITS;
  localparam int FS     = SB - 1;
  localparam int PW     = $clog2(SB);
  localparam int NL_W   = PW + 12;
  localparam int LP_W   = NL_W + 19;
  localparam int RND_SH = 28 - DB_FRAC_BITS;
  localparam int MB     = adrc_pkg::MANT_BITS;
  localparam int STEPS  = adrc_pkg::FRAC_STEPS;
  localparam int CW     = (TIMER_BITS > adrc_pkg::TICKS_W) ? TIMER_BITS : adrc_pkg::TICKS_W;
  localparam int DB_MIN_I = -(128 << DB_FRAC_BITS);
  localparam logic signed [DB_W:0] OV_MAX = (DB_W+1)'(32767);
  localparam logic signed [DB_W:0] OV_MIN = (DB_W+1)'(-32768);

  logic adv;
  logic fire;

  logic          v1, v2, v3, v4, v5;
  logic [SB-1:0] x1, x2, x3, x4, x5;
  logic [SB-1:0] m2, m3;
  logic [PW-1:0] p3, p_lod;
  logic [LP_W-1:0] lp4;
  logic signed [DB_W-1:0] db5;

  logic             sq_v [STEPS+1];
  logic [SB-1:0]    sq_x [STEPS+1];
  logic [PW-1:0]    sq_p [STEPS+1];
  logic [MB-1:0]    sq_y [STEPS+1];
  logic [STEPS-1:0] sq_f [STEPS+1];

  logic [4:0]     lsh;
  logic [PW:0]    e_int;
  logic [NL_W:0]  nl_full;
  logic [LP_W:0]  rsum;
  logic [LP_W:0]  dbm;
  logic signed [DB_W-1:0] db_calc;

  logic                              gate_active, gate_next;
  logic [TIMER_BITS-1:0]             phase_timer, timer_next;
  logic signed [adrc_pkg::OVER_W-1:0] overshoot_db, over_next, ov_sat;
  logic signed [DB_W-1:0]            thr_x;
  logic signed [DB_W:0]              diff;
  logic                              below;

  assign fire = v5 && !q_full;
  assign adv  = !v5 || !q_full;
  assign full = !adv;
  assign q_wr = fire;

  always_comb begin
    p_lod = '0;
    for (int i = 0; i < SB; i++) begin
      if (m2[i]) begin
        p_lod = PW'(i);
      end
    end
  end

  assign lsh     = 5'd23 - 5'(p3);
  assign e_int   = (PW+1)'(FS) - {1'b0, sq_p[STEPS]};
  assign nl_full = {e_int, 12'b0} - (NL_W+1)'(sq_f[STEPS]);
  assign rsum    = (LP_W+1)'(lp4) + ((LP_W+1)'(1) << (RND_SH - 1));
  assign dbm     = rsum >> RND_SH;
  assign db_calc = (x4 == '0) ? DB_W'(DB_MIN_I) : DB_W'(0) - DB_W'(dbm);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      for (int k = 0; k <= STEPS; k++) begin
        sq_v[k] <= 1'b0;
      end
    end else if (adv) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
      sq_v[0] <= v3;
      for (int k = 0; k < STEPS; k++) begin
        sq_v[k+1] <= sq_v[k];
      end
      v4 <= sq_v[STEPS];
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1 <= sample_in;
      x2 <= x1;
      m2 <= x1[SB-1] ? (~x1 + 1'b1) : x1;
      x3 <= x2;
      m3 <= m2;
      p3 <= p_lod;
      sq_x[0] <= x3;
      sq_p[0] <= p3;
      sq_y[0] <= MB'(m3) << lsh;
      sq_f[0] <= '0;
      x4  <= sq_x[STEPS];
      lp4 <= nl_full[NL_W-1:0] * adrc_pkg::LOG_C;
      x5  <= x4;
      db5 <= db_calc;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_sq
    logic [2*MB-1:0] sqr;
    logic [MB:0]     t;
    assign sqr = sq_y[k] * sq_y[k];
    assign t   = sqr[2*MB-1:MB-1];
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_y[k+1] <= t[MB] ? t[MB:1] : t[MB-1:0];
        sq_f[k+1] <= {sq_f[k][STEPS-2:0], t[MB]};
        sq_x[k+1] <= sq_x[k];
        sq_p[k+1] <= sq_p[k];
      end
    end
  end

  assign thr_x = DB_W'(threshold_db);
  assign below = db5 < thr_x;
  assign diff  = (DB_W+1)'(db5) - (DB_W+1)'(thr_x);

  always_comb begin
    if (diff > OV_MAX) begin
      ov_sat = 16'sh7fff;
    end else if (diff < OV_MIN) begin
      ov_sat = -16'sh8000;
    end else begin
      ov_sat = diff[adrc_pkg::OVER_W-1:0];
    end
  end

  always_comb begin
    gate_next  = gate_active;
    timer_next = phase_timer;
    over_next  = overshoot_db;
    q_ctrl     = '0;
    q_op       = overshoot_db;
    q_base     = db5;
    if (below) begin
      q_ctrl.sub = 1'b1;
      if (gate_active) begin
        gate_next   = 1'b0;
        timer_next  = TIMER_BITS'(release_ticks);
        q_ctrl.gain = 1'b1;
      end else if (phase_timer != '0) begin
        q_ctrl.gain = 1'b1;
        timer_next  = phase_timer - 1'b1;
      end
    end else begin
      over_next = ov_sat;
      q_op      = ov_sat;
      q_base    = thr_x;
      if (gate_active) begin
        q_ctrl.gain = 1'b1;
        if (CW'(phase_timer) < CW'(attack_ticks) && phase_timer != '1) begin
          timer_next = phase_timer + 1'b1;
        end
      end else begin
        gate_next  = 1'b1;
        timer_next = '0;
      end
    end
    q_ctrl.gate = gate_next;
  end

  assign q_sample = x5;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_active  <= 1'b0;
      phase_timer  <= '0;
      overshoot_db <= '0;
    end else if (fire) begin
      gate_active  <= gate_next;
      phase_timer  <= timer_next;
      overshoot_db <= over_next;
    end
  end

endmodule

/* design/adrc_back.sv */
// ----------------------------------------------------------------------------
// adrc_back: gain computer
// Pipelined target level, dB-to-log2 scale and 12-stage table exponent,
// then shift, saturation and sign; pass-through requests ride along.
// ----------------------------------------------------------------------------
module adrc_back #(
  parameter int SAMPLE_BITS  = adrc_pkg::SAMPLE_BITS_DEF,
  parameter int DB_FRAC_BITS = adrc_pkg::DB_FRAC_BITS_DEF,
  parameter int DB_W         = adrc_pkg::db_width(DB_FRAC_BITS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  adrc_pkg::ctrl_t                     q_ctrl,
  input  logic [SAMPLE_BITS-1:0]              q_sample,
  input  logic signed [adrc_pkg::OVER_W-1:0]  q_op,
  input  logic signed [DB_W-1:0]              q_base,
  input  logic [adrc_pkg::RATIO_W-1:0]        ratio,
  input  logic                                o_full,
  output logic                                o_wr,
  output logic [SAMPLE_BITS-1:0]              o_sample,
  output logic                                o_gate
);

  localparam int SB    = SAMPLE_BITS;
  localparam int FS    = SB - 1;
  localparam int ND_W  = DB_W + 2;
  localparam int PE_W  = ND_W + 15;
  localparam int IP_W  = PE_W - DB_FRAC_BITS - 16;
  localparam int MB    = adrc_pkg::MANT_BITS;
  localparam int STEPS = adrc_pkg::FRAC_STEPS;
  localparam int SH_OFS = SB - 24;
  localparam logic signed [IP_W:0] SH_HI = (IP_W+1)'(8);
  localparam logic signed [IP_W:0] SH_LO = (IP_W+1)'(-24);
  localparam logic [31:0] MAXM = (32'd1 << FS) - 32'd1;

  logic adv;

  logic            b1_v, b2_v, b3_v;
  adrc_pkg::ctrl_t b1_ctrl, b2_ctrl, b3_ctrl;
  logic [SB-1:0]   b1_x, b2_x, b3_x;
  logic signed [DB_W-1:0] b1_base;
  logic signed [31:0]     b1_prod;
  logic signed [ND_W-1:0] b2_newdb;
  logic signed [PE_W-1:0] b3_pe;

  logic                 ex_v    [STEPS+1];
  adrc_pkg::ctrl_t      ex_ctrl [STEPS+1];
  logic [SB-1:0]        ex_x    [STEPS+1];
  logic [STEPS-1:0]     ex_f    [STEPS+1];
  logic                 ex_sat  [STEPS+1];
  logic                 ex_zr   [STEPS+1];
  logic signed [5:0]    ex_sh   [STEPS+1];
  logic [MB-1:0]        ex_acc  [STEPS+1];

  logic signed [17:0]     q18;
  logic signed [ND_W-1:0] base_x, q_x;
  logic signed [IP_W-1:0] ip;
  logic signed [IP_W:0]   shx;
  logic [5:0]             amt;
  logic [31:0]            wide, mag;
  logic [SB-1:0]          y;

  assign adv   = !ex_v[STEPS] || !o_full;
  assign q_pop = adv && !q_empty;
  assign o_wr  = ex_v[STEPS] && !o_full;

  assign q18    = b1_prod[31:14];
  assign base_x = ND_W'(b1_base);
  assign q_x    = ND_W'(q18);
  assign ip     = b3_pe[PE_W-1:DB_FRAC_BITS+16];
  assign shx    = (IP_W+1)'(ip) + (IP_W+1)'(SH_OFS);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
      for (int k = 0; k <= STEPS; k++) begin
        ex_v[k] <= 1'b0;
      end
    end else if (adv) begin
      b1_v <= !q_empty;
      b2_v <= b1_v;
      b3_v <= b2_v;
      ex_v[0] <= b3_v;
      for (int k = 0; k < STEPS; k++) begin
        ex_v[k+1] <= ex_v[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_ctrl <= q_ctrl;
      b1_x    <= q_sample;
      b1_base <= q_base;
      b1_prod <= q_op * $signed({1'b0, ratio});
      b2_ctrl <= b1_ctrl;
      b2_x    <= b1_x;
      b2_newdb <= b1_ctrl.sub ? base_x - q_x : base_x + q_x;
      b3_ctrl <= b2_ctrl;
      b3_x    <= b2_x;
      b3_pe   <= b2_newdb * $signed({1'b0, adrc_pkg::EXP_K});
      ex_ctrl[0] <= b3_ctrl;
      ex_x[0]    <= b3_x;
      ex_f[0]    <= b3_pe[DB_FRAC_BITS+15:DB_FRAC_BITS+4];
      ex_sat[0]  <= shx > SH_HI;
      ex_zr[0]   <= shx < SH_LO;
      ex_sh[0]   <= shx[5:0];
      ex_acc[0]  <= adrc_pkg::MANT_ONE;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_exp
    logic [2*MB-1:0] prod;
    assign prod = ex_acc[k] * adrc_pkg::POW2_TAB[k] + ((2*MB)'(1) << (MB - 2));
    always_ff @(posedge clk) begin
      if (adv) begin
        ex_acc[k+1]  <= ex_f[k][STEPS-1-k] ? prod[2*MB-2:MB-1] : ex_acc[k];
        ex_ctrl[k+1] <= ex_ctrl[k];
        ex_x[k+1]    <= ex_x[k];
        ex_f[k+1]    <= ex_f[k];
        ex_sat[k+1]  <= ex_sat[k];
        ex_zr[k+1]   <= ex_zr[k];
        ex_sh[k+1]   <= ex_sh[k];
      end
    end
  end

  assign amt  = ex_sh[STEPS][5] ? 6'd0 - ex_sh[STEPS] : ex_sh[STEPS];
  assign wide = ex_sh[STEPS][5] ? ({8'b0, ex_acc[STEPS]} >> amt)
                                : ({8'b0, ex_acc[STEPS]} << amt);

  always_comb begin
    if (ex_zr[STEPS]) begin
      mag = '0;
    end else if (ex_sat[STEPS] || wide > MAXM) begin
      mag = MAXM;
    end else begin
      mag = wide;
    end
  end

  assign y        = ex_x[STEPS][SB-1] ? SB'(0) - SB'(mag) : SB'(mag);
  assign o_sample = ex_ctrl[STEPS].gain ? y : ex_x[STEPS];
  assign o_gate   = ex_ctrl[STEPS].gate;

endmodule
